// ===== rtl/lzw_compressed_length_macros.svh =====
// assertion macros shared by the lzw compressed length checker
`ifndef LZW_COMPRESSED_LENGTH_MACROS_SVH
`define LZW_COMPRESSED_LENGTH_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LZWCL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// next-cycle implication, sampled on clk, off during reset
`define LZWCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

// ===== rtl/lzwcl_pkg.sv =====
// shared types and constants of the lzw compressed length block
`default_nettype none

package lzwcl_pkg;

	localparam int BYTE_BITS       = 8;
	localparam int COUNT_BITS      = 16;
	localparam int EPOCH_BITS      = 8;
	localparam int FIRST_FREE_CODE = 256;

	// controller states, one-hot
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_HASH  = 4'b0100,
		ST_CHECK = 4'b1000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take;        // input transaction accepted
		logic hash_step;   // reduce hash by one table size
		logic probe_start; // issue first table read
		logic check;       // examine read data
		logic clr;         // write one clearing entry
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hash_ready;  // hash below table size
		logic probe_done;  // hit, empty slot or probes exhausted
		logic clr_done;    // last entry of clearing pass
		logic epoch_full;  // epoch wraps on next segment
		logic pend;        // result waiting for output register
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/lzwcl_table.sv =====
// single-port-write, single-port-read dictionary memory with registered read
`default_nettype none

module lzwcl_table #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 5021
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/lzwcl_ctrl.sv =====
// sequencing controller: clearing pass, hash reduction and probe loop
`default_nettype none

module lzwcl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	input  wire logic              first_byte,
	output logic                   byte_ready,
	input  wire lzwcl_pkg::status_t status,
	output lzwcl_pkg::cmd_t        cmd
);

	lzwcl_pkg::state_t state_q, state_d;

	// accept only when idle and no result is stuck
	assign byte_ready = (state_q == lzwcl_pkg::ST_IDLE) && !status.pend;

	// next state and commands
	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		unique case (state_q)
			lzwcl_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_done) begin
					state_d = lzwcl_pkg::ST_IDLE;
				end
			end
			lzwcl_pkg::ST_IDLE: begin
				cmd.take = byte_valid && !status.pend;
				if (cmd.take) begin
					if (!first_byte) begin
						state_d = lzwcl_pkg::ST_HASH;
					end else if (status.epoch_full) begin
						state_d = lzwcl_pkg::ST_CLEAR;
					end
				end
			end
			lzwcl_pkg::ST_HASH: begin
				if (status.hash_ready) begin
					cmd.probe_start = 1'b1;
					state_d         = lzwcl_pkg::ST_CHECK;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			lzwcl_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				if (status.probe_done) begin
					state_d = lzwcl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lzwcl_pkg::ST_CLEAR;
			end
		endcase
	end

	// state register, clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzwcl_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lzwcl_dp.sv =====
// datapath: string state, hash, probe sequence, dictionary and result register
`default_nettype none

module lzwcl_dp #(
	parameter int CODE_BITS   = 12,
	parameter int TABLE_SLOTS = 5021
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [lzwcl_pkg::BYTE_BITS-1:0]     byte_value,
	input  wire logic                                first_byte,
	input  wire logic                                last_byte,
	input  wire lzwcl_pkg::cmd_t                     cmd,
	output lzwcl_pkg::status_t                       status,
	output logic                                     count_valid,
	input  wire logic                                count_ready,
	output logic      [lzwcl_pkg::COUNT_BITS-1:0]    code_count
);

	localparam int IDX_W  = $clog2(TABLE_SLOTS);
	localparam int HASH_W = (CODE_BITS > IDX_W) ? CODE_BITS : IDX_W;
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int EB     = lzwcl_pkg::EPOCH_BITS;
	localparam int BB     = lzwcl_pkg::BYTE_BITS;
	localparam int CB     = lzwcl_pkg::COUNT_BITS;
	localparam int WORD_W = EB + 2 * CODE_BITS + BB;

	localparam logic [CODE_BITS-1:0] LAST_CODE  = CODE_BITS'((1 << CODE_BITS) - 2);
	localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'(lzwcl_pkg::FIRST_FREE_CODE);
	localparam logic [HASH_W-1:0]    SLOTS_H    = HASH_W'(TABLE_SLOTS);
	localparam logic [IDX_W-1:0]     SLOTS_I    = IDX_W'(TABLE_SLOTS);
	localparam logic [IDX_W-1:0]     LAST_SLOT  = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [CNT_W-1:0]     LAST_PROBE = CNT_W'(TABLE_SLOTS - 1);

	// item and string state
	logic [BB-1:0]        byte_q;
	logic                 last_q;
	logic [CODE_BITS-1:0] cur_q;
	logic [CODE_BITS-1:0] next_free_q;
	logic [CB-1:0]        emitted_q;
	logic [EB-1:0]        epoch_q;

	// probe state
	logic [HASH_W-1:0]    hash_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     step_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     clr_addr_q;

	// output stage
	logic                 pend_q;
	logic                 out_valid_q;
	logic [CB-1:0]        count_q;

	// memory ports
	logic                 we;
	logic [IDX_W-1:0]     wr_addr;
	logic [WORD_W-1:0]    wr_data;
	logic [IDX_W-1:0]     rd_addr;
	logic [WORD_W-1:0]    rd_data;

	// combinational helpers
	logic [IDX_W-1:0]     idx0;
	logic [IDX_W-1:0]     next_idx;
	logic [EB-1:0]        rd_tag;
	logic [CODE_BITS-1:0] rd_code;
	logic [CODE_BITS-1:0] rd_prefix;
	logic [BB-1:0]        rd_char;
	logic                 slot_empty;
	logic                 slot_match;
	logic                 exhaust;
	logic                 probe_done;
	logic                 miss;
	logic                 add_code;
	logic [CB-1:0]        emitted_d;
	logic [CB-1:0]        count_d;
	logic                 finish_last;
	logic                 out_free;

	// dictionary memory: tag, code, prefix, char
	lzwcl_table #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_SLOTS)
	) u_table (
		.clk    (clk),
		.we     (we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// unpack read word, entry is live only under the current epoch
	assign rd_tag    = rd_data[WORD_W-1 -: EB];
	assign rd_code   = rd_data[WORD_W-EB-1 -: CODE_BITS];
	assign rd_prefix = rd_data[BB+CODE_BITS-1 -: CODE_BITS];
	assign rd_char   = rd_data[BB-1:0];

	assign slot_empty = (rd_tag != epoch_q);
	assign slot_match = !slot_empty && (rd_prefix == cur_q) && (rd_char == byte_q);
	assign exhaust    = !slot_empty && !slot_match && (cnt_q == LAST_PROBE);
	assign probe_done = slot_empty || slot_match || exhaust;
	assign miss       = cmd.check && (slot_empty || exhaust);
	assign add_code   = cmd.check && slot_empty && (next_free_q <= LAST_CODE);

	// double-hash probe addressing
	assign idx0     = hash_q[IDX_W-1:0];
	assign next_idx = (idx_q >= step_q) ? (idx_q - step_q) : (idx_q + (SLOTS_I - step_q));
	assign rd_addr  = cmd.probe_start ? idx0 : next_idx;

	// write port: clearing pass or new dictionary entry
	assign we      = cmd.clr || add_code;
	assign wr_addr = cmd.clr ? clr_addr_q : idx_q;
	assign wr_data = cmd.clr ? '0 : {epoch_q, next_free_q, cur_q, byte_q};

	// emitted count after this cycle and the saturating total
	always_comb begin
		emitted_d = emitted_q;
		if (cmd.take && first_byte) begin
			emitted_d = '0;
		end else if (miss && (emitted_q != '1)) begin
			emitted_d = emitted_q + CB'(1);
		end
	end
	assign count_d = (emitted_d == '1) ? emitted_d : (emitted_d + CB'(1));

	assign finish_last = (cmd.take && first_byte && last_byte)
		|| (cmd.check && probe_done && last_q);
	assign out_free    = !out_valid_q || count_ready;

	assign status.hash_ready = (hash_q < SLOTS_H);
	assign status.probe_done = probe_done;
	assign status.clr_done   = (clr_addr_q == LAST_SLOT);
	assign status.epoch_full = (epoch_q == '1);
	assign status.pend       = pend_q;

	assign count_valid = out_valid_q;
	assign code_count  = count_q;

	// item registers and hash
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= byte_value;
			last_q <= last_byte;
			hash_q <= HASH_W'({byte_value, {(CODE_BITS - BB){1'b0}}} ^ cur_q);
		end else if (cmd.hash_step) begin
			hash_q <= hash_q - SLOTS_H;
		end
	end

	// probe index, step and count
	always_ff @(posedge clk) begin
		if (cmd.probe_start) begin
			idx_q  <= idx0;
			step_q <= (idx0 == '0) ? IDX_W'(1) : (SLOTS_I - idx0);
			cnt_q  <= '0;
		end else if (cmd.check && !probe_done) begin
			idx_q <= next_idx;
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// string state, code allocation, epoch and clearing address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			next_free_q <= FIRST_FREE;
			emitted_q   <= '0;
			epoch_q     <= EB'(1);
			clr_addr_q  <= '0;
		end else begin
			emitted_q <= emitted_d;
			if (cmd.take && first_byte) begin
				cur_q       <= CODE_BITS'(byte_value);
				next_free_q <= FIRST_FREE;
				epoch_q     <= (epoch_q == '1) ? EB'(1) : (epoch_q + EB'(1));
			end else if (cmd.check && slot_match) begin
				cur_q <= rd_code;
			end else if (miss) begin
				cur_q <= CODE_BITS'(byte_q);
			end
			if (add_code) begin
				next_free_q <= next_free_q + CODE_BITS'(1);
			end
			if (cmd.clr) begin
				clr_addr_q <= status.clr_done ? '0 : (clr_addr_q + IDX_W'(1));
			end
		end
	end

	// result register with a one-deep pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= (pend_q || finish_last) && !out_free;
			if ((finish_last || pend_q) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (count_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((finish_last || pend_q) && out_free) begin
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/lzw_compressed_length.sv =====
// Counts the 12-bit LZW codes that a byte segment compresses to, using a hashed dictionary
// in a single synchronous memory. A byte with first_byte set opens a segment. Any other
// byte passes through accept, hash and check, with one more check for each extra probe
// after a collision and one more hash step for each table size the start hash must be
// reduced by (none at the default sizes); the memory's one read per cycle sets the probe
// pace. After reset, and again at the start of every 255th segment, a clearing pass over
// all TABLE_SLOTS entries (5021 by default) runs with byte_ready low. The count for a
// last_byte item appears on code_count the cycle after that item finishes; while an earlier
// count still waits on count_ready it appears the cycle after that one is taken, and
// byte_ready stays low until then.
`default_nettype none

module lzw_compressed_length #(
	parameter int CODE_BITS   = 12,
	parameter int TABLE_SLOTS = 5021
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             byte_valid,
	output logic                                  byte_ready,
	input  wire logic [lzwcl_pkg::BYTE_BITS-1:0]  byte_value,
	input  wire logic                             first_byte,
	input  wire logic                             last_byte,
	output logic                                  count_valid,
	input  wire logic                             count_ready,
	output logic      [lzwcl_pkg::COUNT_BITS-1:0] code_count
);

	lzwcl_pkg::cmd_t    cmd;
	lzwcl_pkg::status_t status;

	// sequencing
	lzwcl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.first_byte(first_byte),
		.byte_ready(byte_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// dictionary and counters
	lzwcl_dp #(
		.CODE_BITS  (CODE_BITS),
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_value),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.cmd        (cmd),
		.status     (status),
		.count_valid(count_valid),
		.count_ready(count_ready),
		.code_count (code_count)
	);

endmodule

`default_nettype wire

// ===== rtl/lzwcl_checker.sv =====
// port-level checks of the lzw compressed length block and their bind
`default_nettype none

`include "lzw_compressed_length_macros.svh"

module lzwcl_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             byte_valid,
	input wire logic                             byte_ready,
	input wire logic                             first_byte,
	input wire logic                             last_byte,
	input wire logic                             count_valid,
	input wire logic                             count_ready,
	input wire logic [lzwcl_pkg::COUNT_BITS-1:0] code_count
);

	// a stalled result holds
	`LZWCL_ASSERT_NEXT(a_count_hold, count_valid && !count_ready, count_valid && $stable(code_count))

	// every segment needs at least one code
	`LZWCL_ASSERT_NOW(a_count_nonzero, count_valid, code_count != '0)

	// a one-byte segment reports a single code right away
	`LZWCL_ASSERT_NEXT(a_single_byte, byte_valid && byte_ready && first_byte && last_byte && !count_valid, count_valid && (code_count == lzwcl_pkg::COUNT_BITS'(1)))

	// a continuing byte keeps the block busy for its lookup
	`LZWCL_ASSERT_NEXT(a_lookup_busy, byte_valid && byte_ready && !first_byte, !byte_ready)

endmodule

bind lzw_compressed_length lzwcl_checker u_lzwcl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_ready (byte_ready),
	.first_byte (first_byte),
	.last_byte  (last_byte),
	.count_valid(count_valid),
	.count_ready(count_ready),
	.code_count (code_count)
);

`default_nettype wire

// ===== test/lzw_compressed_length_checker.sv =====
// checker for lzw_compressed_length: predicts each code count and compares results
module lzw_compressed_length_checker #(
	parameter int CODE_BITS   = 12,
	parameter int TABLE_SLOTS = 5021
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 byte_valid,
	input  logic                                 byte_ready,
	input  logic [lzwcl_pkg::BYTE_BITS-1:0]      byte_value,
	input  logic                                 first_byte,
	input  logic                                 last_byte,
	input  logic                                 count_valid,
	input  logic                                 count_ready,
	input  logic [lzwcl_pkg::COUNT_BITS-1:0]     code_count,
	output int                                   fail_count,
	output int                                   counts_pending,
	output int                                   counts_checked,
	output bit                                   saw_full,
	output bit                                   saw_saturation
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LAST_CODE = (1 << CODE_BITS) - 2;
	localparam int unsigned COUNT_MAX = (1 << lzwcl_pkg::COUNT_BITS) - 1;

	// dictionary image, one entry per hash slot
	bit                                dict_used   [TABLE_SLOTS];
	bit [CODE_BITS-1:0]                dict_code   [TABLE_SLOTS];
	bit [CODE_BITS-1:0]                dict_prefix [TABLE_SLOTS];
	bit [lzwcl_pkg::BYTE_BITS-1:0]     dict_char   [TABLE_SLOTS];

	// running segment state
	bit [CODE_BITS-1:0] cur_str;
	int unsigned        free_code = lzwcl_pkg::FIRST_FREE_CODE;
	int unsigned        codes_out;

	// code counts still to come from the block, oldest first
	bit [lzwcl_pkg::COUNT_BITS-1:0] counts_due [$];

	// double-hash probe: finds a free slot or the slot holding (pfx, ch)
	function automatic bit dict_probe(input bit [CODE_BITS-1:0] pfx,
			input bit [lzwcl_pkg::BYTE_BITS-1:0] ch, output int unsigned slot);
		int unsigned idx;
		int unsigned stride;
		int          n;
		idx = int'(ch) << (CODE_BITS - 8);
		idx = (idx ^ int'(pfx)) % TABLE_SLOTS;
		stride = (idx == 0) ? 1 : TABLE_SLOTS - idx;
		slot = 0;
		for (n = 0; n < TABLE_SLOTS; n++) begin
			if (!dict_used[idx] || (dict_prefix[idx] == pfx && dict_char[idx] == ch)) begin
				slot = idx;
				return 1'b1;
			end
			idx = (idx >= stride) ? idx - stride : idx + TABLE_SLOTS - stride;
		end
		return 1'b0;
	endfunction

	// advance the compressor by one byte, queue a count on the last byte
	function automatic void lzw_absorb_byte(input bit [lzwcl_pkg::BYTE_BITS-1:0] ch,
			input bit opens, input bit closes);
		int unsigned slot;
		int unsigned total;
		bit          found;
		if (opens) begin
			foreach (dict_used[i]) dict_used[i] = 1'b0;
			free_code = lzwcl_pkg::FIRST_FREE_CODE;
			codes_out = 0;
			cur_str = ch;
		end else begin
			found = dict_probe(cur_str, ch, slot);
			if (found && dict_used[slot]) begin
				cur_str = dict_code[slot];
			end else begin
				// new string while codes remain, else only counted
				if (found && free_code <= LAST_CODE) begin
					dict_used[slot] = 1'b1;
					dict_code[slot] = free_code[CODE_BITS-1:0];
					dict_prefix[slot] = cur_str;
					dict_char[slot] = ch;
					free_code++;
				end else if (free_code > LAST_CODE) begin
					saw_full = 1'b1;
				end
				if (codes_out < COUNT_MAX)
					codes_out++;
				else
					saw_saturation = 1'b1;
				cur_str = ch;
			end
		end
		if (closes) begin
			total = codes_out + 1;
			if (total > COUNT_MAX)
				total = COUNT_MAX;
			counts_due.push_back(total[lzwcl_pkg::COUNT_BITS-1:0]);
		end
	endfunction

	// watch both channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (dict_used[i]) dict_used[i] = 1'b0;
			cur_str = '0;
			free_code = lzwcl_pkg::FIRST_FREE_CODE;
			codes_out = 0;
			counts_due.delete();
			counts_pending = 0;
		end else begin
			// byte transaction
			if (byte_valid && byte_ready)
				lzw_absorb_byte(byte_value, first_byte, last_byte);
			// count transaction
			if (count_valid && count_ready) begin
				if (counts_due.size() == 0) begin
					$error("code_count: no count expected, got %0d", code_count);
					fail_count++;
				end else begin
					bit [lzwcl_pkg::COUNT_BITS-1:0] want;
					want = counts_due.pop_front();
					counts_checked++;
					if (code_count !== want) begin
						$error("code_count: expected %0d, actual %0d", want, code_count);
						fail_count++;
					end
				end
			end
			counts_pending = counts_due.size();
		end
	end

endmodule

// ===== test/tb_lzw_compressed_length.sv =====
// testbench top for lzw_compressed_length: byte stimulus, count receiver and verdict
module tb_lzw_compressed_length;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CODE_BITS          = 12;
	localparam int TABLE_SLOTS        = 5021;
	localparam int RANDOM_BYTES       = 930;
	localparam int LONG_SEGMENT_BYTES = 120;

	typedef enum int {TEXT_NARROW, TEXT_WIDE, TEXT_RUNS} text_style_t;
	typedef enum int {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_style_t;

	logic                             clk;
	logic                             arst_n;
	logic                             byte_valid;
	logic                             byte_ready;
	logic [lzwcl_pkg::BYTE_BITS-1:0]  byte_value;
	logic                             first_byte;
	logic                             last_byte;
	logic                             count_valid;
	logic                             count_ready;
	logic [lzwcl_pkg::COUNT_BITS-1:0] code_count;

	int fail_count;
	int counts_pending;
	int counts_checked;
	bit saw_full;
	bit saw_saturation;

	int burst_left = 1;
	int bytes_sent;
	int segments_sent;
	bit steady_tx;

	lzw_compressed_length #(
		.CODE_BITS(CODE_BITS),
		.TABLE_SLOTS(TABLE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_value(byte_value),
		.first_byte(first_byte),
		.last_byte(last_byte),
		.count_valid(count_valid),
		.count_ready(count_ready),
		.code_count(code_count)
	);

	lzw_compressed_length_checker #(
		.CODE_BITS(CODE_BITS),
		.TABLE_SLOTS(TABLE_SLOTS)
	) count_check (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_value(byte_value),
		.first_byte(first_byte),
		.last_byte(last_byte),
		.count_valid(count_valid),
		.count_ready(count_ready),
		.code_count(code_count),
		.fail_count(fail_count),
		.counts_pending(counts_pending),
		.counts_checked(counts_checked),
		.saw_full(saw_full),
		.saw_saturation(saw_saturation)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial begin
		#40_000_000;
		$display("timeout with %0d counts outstanding", counts_pending);
		$display("lzw_compressed_length verification failed");
		$finish;
	end

	// count receiver: stall pattern changes at random
	initial begin
		rx_style_t rx_style;
		int        hold;
		count_ready = 1'b0;
		forever begin
			rx_style = rx_style_t'($urandom_range(0, 2));
			hold = $urandom_range(20, 200);
			repeat (hold) begin
				@(negedge clk);
				case (rx_style)
					RX_OPEN:    count_ready <= 1'b1;
					RX_CHOPPY:  count_ready <= 1'($urandom_range(0, 1));
					RX_STARVED: count_ready <= ($urandom_range(0, 3) == 0);
					default:    count_ready <= 1'b1;
				endcase
			end
		end
	end

	// one byte transaction, then the burst and gap pattern of the sender
	task automatic send_byte(input logic [lzwcl_pkg::BYTE_BITS-1:0] v, input logic opens,
			input logic closes);
		int gap;
		byte_valid <= 1'b1;
		byte_value <= v;
		first_byte <= opens;
		last_byte <= closes;
		do @(posedge clk); while (!byte_ready);
		@(negedge clk);
		bytes_sent++;
		if (opens)
			segments_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (steady_tx || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	// sender holds off until every count has come back
	task automatic hold_until_drained();
		byte_valid <= 1'b0;
		while (counts_pending != 0) @(negedge clk);
	endtask

	// a segment of random content, flags optional for broken sequences
	task automatic send_segment(input int len, input bit with_first, input bit with_last,
			input text_style_t text_style);
		logic [lzwcl_pkg::BYTE_BITS-1:0] base;
		logic [lzwcl_pkg::BYTE_BITS-1:0] v;
		int                              i;
		base = 8'($urandom_range(0, 255));
		for (i = 0; i < len; i++) begin
			case (text_style)
				TEXT_NARROW: v = base + 8'($urandom_range(0, 3));
				TEXT_WIDE:   v = 8'($urandom_range(0, 255));
				TEXT_RUNS: begin
					if ($urandom_range(0, 4) == 0)
						base = 8'($urandom_range(0, 255));
					v = base;
				end
				default:     v = base;
			endcase
			send_byte(v, with_first && i == 0, with_last && i == len - 1);
		end
	endtask

	// stimulus and verdict
	initial begin
		int          random_bytes;
		int          len;
		int          pick;
		bit          paused;
		text_style_t text_style;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		byte_value = '0;
		first_byte = 1'b0;
		last_byte = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// no first flag after reset: continues from the reset state
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		// one-byte segments at both byte extremes
		send_byte(8'hFF, 1'b1, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
		// one repeated byte grows ever longer strings
		send_byte(8'h41, 1'b1, 1'b0);
		repeat (6) send_byte(8'h41, 1'b0, 1'b0);
		send_byte(8'h41, 1'b0, 1'b1);
		// alternating bit patterns
		send_byte(8'h80, 1'b1, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b0);
		send_byte(8'hFE, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'h7F, 1'b0, 1'b1);
		// finished segment continued without a first flag
		send_byte(8'h55, 1'b0, 1'b1);
		// segment abandoned without a last flag, then a fresh one
		send_byte(8'hAA, 1'b1, 1'b0);
		send_byte(8'h55, 1'b0, 1'b0);
		send_byte(8'hAA, 1'b1, 1'b1);
		hold_until_drained();

		// one longer segment of wide text: many dictionary additions back to back
		steady_tx = 1'b1;
		send_segment(LONG_SEGMENT_BYTES, 1'b1, 1'b1, TEXT_WIDE);
		steady_tx = 1'b0;
		hold_until_drained();

		// random segments, mostly short so the segment count runs past the epoch wrap
		while (random_bytes < RANDOM_BYTES) begin
			pick = $urandom_range(0, 99);
			if (pick < 90)
				len = $urandom_range(1, 3);
			else if (pick < 98)
				len = $urandom_range(4, 10);
			else
				len = $urandom_range(11, 40);
			text_style = text_style_t'($urandom_range(0, 2));
			send_segment(len, $urandom_range(0, 99) >= 8, $urandom_range(0, 99) >= 8,
				text_style);
			random_bytes += len;
			if (!paused && random_bytes >= RANDOM_BYTES / 2) begin
				hold_until_drained();
				paused = 1'b1;
			end
		end

		// let the last counts arrive, then a little more for stray results
		hold_until_drained();
		repeat (40) @(negedge clk);

		$display("sent %0d bytes, %0d segments opened, %0d counts compared",
			bytes_sent, segments_sent, counts_checked);
		$display("dictionary filled: %0s, code count saturated: %0s",
			saw_full ? "yes" : "no", saw_saturation ? "yes" : "no");
		if (fail_count == 0)
			$display("lzw_compressed_length verification clean");
		else
			$display("lzw_compressed_length verification failed");
		$finish;
	end

endmodule

// ===== lzw_compressed_length.f =====
+incdir+rtl
rtl/lzwcl_pkg.sv
rtl/lzwcl_table.sv
rtl/lzwcl_ctrl.sv
rtl/lzwcl_dp.sv
rtl/lzw_compressed_length.sv
rtl/lzwcl_checker.sv
test/lzw_compressed_length_checker.sv
test/tb_lzw_compressed_length.sv
